// ===== hw/rtl/scds_pkg.sv =====
// Package for the serial clock divider search.
// Widths, limits and the sequencer state type; no dependencies.
package scds_pkg;

	localparam int BUS_W        = 27;          // bus clock and target width
	localparam int DIV_W        = BUS_W + 1;   // numerator width of the shared divider
	localparam int CNT_W        = 5;           // step counter, holds DIV_W - 1
	localparam int MAX_DIVIDER  = 64;
	localparam int MAX_PRESCALE = 8192;
	localparam int N_W          = 7;           // holds 2..MAX_DIVIDER
	localparam int PRE_W        = 14;          // holds 1..MAX_PRESCALE
	localparam int PROD_W       = PRE_W + N_W;
	localparam int PRE_OUT_W    = 13;
	localparam int DIVR_OUT_W   = 6;
	localparam int HIGH_W       = 5;
	localparam int WORD_W       = 31;

	localparam logic [BUS_W-1:0] BUS_RESET = 27'd80000000;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_DIV1  = 8'b0000_0100,
		ST_DIV2  = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_DIV3  = 8'b0010_0000,
		ST_CMP   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

endpackage

// ===== hw/rtl/spi_clock_divider_search.sv =====
// Serial clock divider search: top level, sequencer and bit-serial divider.
// Depends on scds_pkg.
//
// channel  dir  handshake            payload
// cfg      in   cfg_valid/cfg_ready  bus_clock_hz (27b)
// in       in   in_valid/in_ready    target_hz (27b)
// out      out  out_valid/out_ready  bypass, prescale_minus_one, divider_minus_one,
//                                    high_count, low_count, clock_word
//
// A bypass request goes from accept through the check state to done. Otherwise each
// divider trial runs three 28-step divisions at one quotient bit per cycle on the
// single shared divider, plus a multiply and a compare state, and a request runs
// at most 63 trials.
// Reset: arst_n clears the sequencer and output valid, and loads the bus clock
// register with 80 MHz. One request is in work at a time; in_ready is high only
// when idle. A finished result waits in the output register while the next request
// is accepted; a new result waits in the done state while out_valid stays stalled.
module spi_clock_divider_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scds_pkg::BUS_W-1:0]          bus_clock_hz,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [scds_pkg::BUS_W-1:0]          target_hz,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                bypass,
	output logic [scds_pkg::PRE_OUT_W-1:0]      prescale_minus_one,
	output logic [scds_pkg::DIVR_OUT_W-1:0]     divider_minus_one,
	output logic [scds_pkg::HIGH_W-1:0]         high_count,
	output logic [scds_pkg::DIVR_OUT_W-1:0]     low_count,
	output logic [scds_pkg::WORD_W-1:0]         clock_word
);

	scds_pkg::state_t state_q;

	logic [scds_pkg::BUS_W-1:0]      bus_q;
	logic [scds_pkg::BUS_W-1:0]      target_q;
	logic                            bypass_q;
	logic [scds_pkg::N_W-1:0]        n_q;
	logic [scds_pkg::PRE_W-1:0]      pre_q;
	logic [scds_pkg::BUS_W-1:0]      err_q;
	logic [scds_pkg::BUS_W-1:0]      best_err_q;
	logic [scds_pkg::DIVR_OUT_W-1:0] best_div_q;
	logic [scds_pkg::PRE_OUT_W-1:0]  best_pre_q;

	// shared restoring divider: quotient shifts into num_q from the bottom
	logic [scds_pkg::DIV_W-1:0]      num_q;
	logic [scds_pkg::BUS_W-1:0]      den_q;
	logic [scds_pkg::BUS_W-1:0]      rem_q;
	logic [scds_pkg::CNT_W-1:0]      cnt_q;

	logic                            out_valid_q;
	logic                            bypass_out_q;
	logic [scds_pkg::PRE_OUT_W-1:0]  pre_out_q;
	logic [scds_pkg::DIVR_OUT_W-1:0] div_out_q;
	logic [scds_pkg::HIGH_W-1:0]     high_out_q;

	logic [scds_pkg::DIV_W-1:0]      shifted;
	logic [scds_pkg::DIV_W-1:0]      diff;
	logic                            take;
	logic [scds_pkg::BUS_W-1:0]      rem_next;
	logic [scds_pkg::DIV_W-1:0]      quo_next;
	logic                            last_step;
	logic                            dividing;
	logic [scds_pkg::BUS_W-1:0]      threshold;
	logic                            over;
	logic [scds_pkg::PRE_W-1:0]      pre_clamped;
	logic [scds_pkg::PROD_W-1:0]     prod;
	logic [scds_pkg::DIV_W-1:0]      err_wide;
	logic                            better;
	logic                            stop_search;
	logic                            out_free;
	logic [scds_pkg::DIVR_OUT_W-1:0] high_src;

	// one quotient bit per cycle
	always_comb begin
		shifted   = {rem_q, num_q[scds_pkg::DIV_W-1]};
		diff      = shifted - {1'b0, den_q};
		take      = (shifted >= {1'b0, den_q});
		rem_next  = take ? diff[scds_pkg::BUS_W-1:0] : shifted[scds_pkg::BUS_W-1:0];
		quo_next  = {num_q[scds_pkg::DIV_W-2:0], take};
		last_step = (cnt_q == scds_pkg::CNT_W'(scds_pkg::DIV_W - 1));
		dividing  = (state_q == scds_pkg::ST_DIV1) || (state_q == scds_pkg::ST_DIV2) ||
		            (state_q == scds_pkg::ST_DIV3);
	end

	// bypass threshold: (bus >> 2) * 3
	always_comb begin
		threshold = scds_pkg::BUS_W'({bus_q[scds_pkg::BUS_W-1:2], 1'b0}) +
		            scds_pkg::BUS_W'(bus_q[scds_pkg::BUS_W-1:2]);
		over      = (target_q > threshold);
	end

	// prescaler clamp to 1..MAX_PRESCALE, product, error
	always_comb begin
		if (quo_next == '0) begin
			pre_clamped = scds_pkg::PRE_W'(1);
		end else if (quo_next > scds_pkg::DIV_W'(scds_pkg::MAX_PRESCALE)) begin
			pre_clamped = scds_pkg::PRE_W'(scds_pkg::MAX_PRESCALE);
		end else begin
			pre_clamped = quo_next[scds_pkg::PRE_W-1:0];
		end
		prod = scds_pkg::PROD_W'(pre_q) * scds_pkg::PROD_W'(n_q);
		if (quo_next >= {1'b0, target_q}) begin
			err_wide = quo_next - {1'b0, target_q};
		end else begin
			err_wide = {1'b0, target_q} - quo_next;
		end
		better      = (err_q < best_err_q);
		stop_search = (better && (err_q == '0)) ||
		              (n_q == scds_pkg::N_W'(scds_pkg::MAX_DIVIDER));
	end

	assign out_free = !out_valid_q || out_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scds_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bus_q       <= scds_pkg::BUS_RESET;
		end else begin
			if (cfg_valid) begin
				bus_q <= bus_clock_hz;
			end
			// a new result may replace the one leaving in the same cycle
			if ((state_q == scds_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				scds_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= scds_pkg::ST_CHECK;
					end
				end
				scds_pkg::ST_CHECK: begin
					state_q <= over ? scds_pkg::ST_DONE : scds_pkg::ST_DIV1;
				end
				scds_pkg::ST_DIV1: begin
					if (last_step) begin
						state_q <= scds_pkg::ST_DIV2;
					end
				end
				scds_pkg::ST_DIV2: begin
					if (last_step) begin
						state_q <= scds_pkg::ST_MUL;
					end
				end
				scds_pkg::ST_MUL: begin
					state_q <= scds_pkg::ST_DIV3;
				end
				scds_pkg::ST_DIV3: begin
					if (last_step) begin
						state_q <= scds_pkg::ST_CMP;
					end
				end
				scds_pkg::ST_CMP: begin
					state_q <= stop_search ? scds_pkg::ST_DONE : scds_pkg::ST_DIV1;
				end
				scds_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= scds_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= scds_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath; the last quotient bit is taken straight from quo_next
	always_ff @(posedge clk) begin
		if (dividing && !last_step) begin
			num_q <= quo_next;
			rem_q <= rem_next;
			cnt_q <= cnt_q + scds_pkg::CNT_W'(1);
		end
		case (state_q)
			scds_pkg::ST_IDLE: begin
				if (in_valid) begin
					// a zero target counts as one
					target_q <= (target_hz == '0) ? scds_pkg::BUS_W'(1) : target_hz;
				end
			end
			scds_pkg::ST_CHECK: begin
				bypass_q   <= over;
				best_err_q <= bus_q;
				best_div_q <= '0;
				best_pre_q <= '0;
				n_q        <= scds_pkg::N_W'(2);
				num_q      <= {1'b0, bus_q};
				den_q      <= scds_pkg::BUS_W'(2);
				rem_q      <= '0;
				cnt_q      <= '0;
			end
			scds_pkg::ST_DIV1: begin
				if (last_step) begin
					// rounded prescaler numerator: bus/n + target/2
					num_q <= quo_next + scds_pkg::DIV_W'(target_q >> 1);
					den_q <= target_q;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			scds_pkg::ST_DIV2: begin
				if (last_step) begin
					pre_q <= pre_clamped;
				end
			end
			scds_pkg::ST_MUL: begin
				num_q <= {1'b0, bus_q};
				den_q <= scds_pkg::BUS_W'(prod);
				rem_q <= '0;
				cnt_q <= '0;
			end
			scds_pkg::ST_DIV3: begin
				if (last_step) begin
					err_q <= err_wide[scds_pkg::BUS_W-1:0];
				end
			end
			scds_pkg::ST_CMP: begin
				if (better) begin
					best_err_q <= err_q;
					best_div_q <= scds_pkg::DIVR_OUT_W'(n_q - scds_pkg::N_W'(1));
					best_pre_q <= scds_pkg::PRE_OUT_W'(pre_q - scds_pkg::PRE_W'(1));
				end
				n_q   <= n_q + scds_pkg::N_W'(1);
				num_q <= {1'b0, bus_q};
				den_q <= scds_pkg::BUS_W'(n_q + scds_pkg::N_W'(1));
				rem_q <= '0;
				cnt_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// high phase count: (divider - 1) >> 1, zero for divider zero
	always_comb begin
		high_src = (best_div_q == '0) ? '0 : (best_div_q - scds_pkg::DIVR_OUT_W'(1));
	end

	// output register
	always_ff @(posedge clk) begin
		if ((state_q == scds_pkg::ST_DONE) && out_free) begin
			bypass_out_q <= bypass_q;
			if (bypass_q) begin
				pre_out_q  <= '0;
				div_out_q  <= '0;
				high_out_q <= '0;
			end else begin
				pre_out_q  <= best_pre_q;
				div_out_q  <= best_div_q;
				high_out_q <= high_src[scds_pkg::HIGH_W:1];
			end
		end
	end

	assign cfg_ready          = 1'b1;
	assign in_ready           = (state_q == scds_pkg::ST_IDLE);
	assign out_valid          = out_valid_q;
	assign bypass             = bypass_out_q;
	assign prescale_minus_one = pre_out_q;
	assign divider_minus_one  = div_out_q;
	assign high_count         = high_out_q;
	assign low_count          = div_out_q;
	// prescale at 18, divider at 12, high at 6, low at 0
	assign clock_word         = {pre_out_q, div_out_q, 1'b0, high_out_q, div_out_q};

endmodule
